// ===== hdl/wpcm_pkg.sv =====
package wpcm_pkg;

   localparam int MAX_WINDOW  = 1024;
   localparam int MAX_LENGTH  = 65536;
   localparam int SAMPLE_W    = 32;
   localparam int CFG_W       = 11;
   localparam int POS_W       = 17;
   localparam int ADDR_W      = 10;
   localparam int PEAK_W      = 10;
   localparam int START_W     = 17;
   localparam int OFFSET_W    = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int MIN_WINDOW  = 3;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_LONG  = 2'd2
   } status_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [PEAK_W-1:0]  best_peaks;
      logic [START_W-1:0] best_start;
      logic [1:0]         status;
   } rsp_type;

   // classified sample passed from front to back
   typedef struct packed {
      logic                flag;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic                sub;
      logic [ADDR_W-1:0]   rd_addr;
      logic                cand;
      logic                first;
      logic [OFFSET_W-1:0] start;
      logic                last;
      status_type          status;
   } entry_type;

endpackage

// ===== hdl/window_peak_count_max_core.sv =====
// Channel   Ports                              Transaction when
// -------   --------------------------------   ---------------------------
// input     req_push req_full req_data         req_push && !req_full
// result    rsp_empty rsp_pop rsp_data         rsp_pop && !rsp_empty
// config    csr_write_en csr_write_data        csr_write_en
//
// One sample per cycle sustained unless a held result fills the queue; a result
// reaches the result ports through the queue write, flag memory read and count update.
// The window count update and the 1024-entry flag ring set the rate.
// Synchronous active-high reset; the flag ring needs no clearing pass.
// A 4-entry queue decouples classification from counting; a held result
// stalls counting only when another last sample reaches the count stage.
module window_peak_count_max_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  wpcm_pkg::req_type          req_data,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output wpcm_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_en,
   input  logic [wpcm_pkg::CFG_W-1:0] csr_write_data
);

   wpcm_pkg::entry_type entry;
   wpcm_pkg::entry_type head;
   logic                accept;
   logic                head_empty;
   logic                head_pop;

   assign accept = req_push && !req_full;

   wpcm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .req_data       (req_data),
      .entry          (entry)
   );

   wpcm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (entry),
      .full      (req_full),
      .pop       (head_pop),
      .head      (head),
      .empty     (head_empty)
   );

   wpcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule

// ===== hdl/wpcm_front.sv =====
module wpcm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [wpcm_pkg::CFG_W-1:0]  csr_write_data,
   input  logic                        accept,
   input  wpcm_pkg::req_type           req_data,
   output wpcm_pkg::entry_type         entry
);

   logic [wpcm_pkg::CFG_W-1:0]    window_ff, window_in;
   logic [wpcm_pkg::CFG_W-1:0]    active_ff, active_in;
   logic [wpcm_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [wpcm_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic [wpcm_pkg::SAMPLE_W-1:0] bprev_ff, bprev_in;

   logic [wpcm_pkg::CFG_W-1:0]    k;
   logic [wpcm_pkg::POS_W-1:0]    kp;
   logic [wpcm_pkg::POS_W-1:0]    pm1;
   logic [wpcm_pkg::POS_W-1:0]    diff;
   logic                          in_range;
   logic                          peak;

   always_comb begin
      window_in = window_ff;
      if (csr_write_en) begin
         if (csr_write_data < wpcm_pkg::CFG_W'(wpcm_pkg::MIN_WINDOW)) begin
            window_in = wpcm_pkg::CFG_W'(wpcm_pkg::MIN_WINDOW);
         end else if (csr_write_data > wpcm_pkg::CFG_W'(wpcm_pkg::MAX_WINDOW)) begin
            window_in = wpcm_pkg::CFG_W'(wpcm_pkg::MAX_WINDOW);
         end else begin
            window_in = csr_write_data;
         end
      end
   end

   always_comb begin
      k        = (pos_ff == '0) ? window_ff : active_ff;
      kp       = wpcm_pkg::POS_W'(k);
      in_range = pos_ff < wpcm_pkg::POS_W'(wpcm_pkg::MAX_LENGTH);
      peak     = (pos_ff >= wpcm_pkg::POS_W'(2)) && (prev_ff > bprev_ff) &&
                 (prev_ff > req_data.sample);
      pm1      = pos_ff - wpcm_pkg::POS_W'(1);
      diff     = pos_ff - kp + wpcm_pkg::POS_W'(1);

      entry.flag    = in_range && peak;
      entry.wr_en   = in_range && (pos_ff != '0);
      entry.wr_addr = pm1[wpcm_pkg::ADDR_W-1:0];
      entry.sub     = in_range && (pos_ff >= kp);
      entry.rd_addr = diff[wpcm_pkg::ADDR_W-1:0];
      entry.cand    = in_range && ((pos_ff + wpcm_pkg::POS_W'(1)) >= kp);
      entry.first   = (diff == '0);
      entry.start   = diff[wpcm_pkg::OFFSET_W-1:0];
      entry.last    = req_data.last;
      if (!in_range) begin
         entry.status = wpcm_pkg::STATUS_LONG;
      end else if ((pos_ff + wpcm_pkg::POS_W'(1)) < kp) begin
         entry.status = wpcm_pkg::STATUS_SHORT;
      end else begin
         entry.status = wpcm_pkg::STATUS_OK;
      end
   end

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      bprev_in  = bprev_ff;
      if (accept) begin
         active_in = k;
         if (in_range) begin
            prev_in  = req_data.sample;
            bprev_in = prev_ff;
         end
         if (pos_ff <= wpcm_pkg::POS_W'(wpcm_pkg::MAX_LENGTH)) begin
            pos_in = pos_ff + wpcm_pkg::POS_W'(1);
         end
         if (req_data.last) begin
            pos_in   = '0;
            prev_in  = '0;
            bprev_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= wpcm_pkg::CFG_W'(wpcm_pkg::MIN_WINDOW);
         active_ff <= wpcm_pkg::CFG_W'(wpcm_pkg::MIN_WINDOW);
         pos_ff    <= '0;
         prev_ff   <= '0;
         bprev_ff  <= '0;
      end else begin
         window_ff <= window_in;
         active_ff <= active_in;
         pos_ff    <= pos_in;
         prev_ff   <= prev_in;
         bprev_ff  <= bprev_in;
      end
   end

endmodule

// ===== hdl/wpcm_queue.sv =====
module wpcm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wpcm_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output wpcm_pkg::entry_type head,
   output logic                empty
);

   wpcm_pkg::entry_type              slot_ff [wpcm_pkg::QUEUE_DEPTH];
   logic [wpcm_pkg::QPTR_W-1:0]      wr_ff, wr_in;
   logic [wpcm_pkg::QPTR_W-1:0]      rd_ff, rd_in;
   logic [wpcm_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                             do_push;
   logic                             do_pop;

   assign full    = (cnt_ff == wpcm_pkg::QCNT_W'(wpcm_pkg::QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + wpcm_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + wpcm_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + wpcm_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - wpcm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== hdl/wpcm_back.sv =====
module wpcm_back (
   input  logic                clock,
   input  logic                reset,
   input  wpcm_pkg::entry_type head,
   input  logic                head_empty,
   output logic                head_pop,
   output wpcm_pkg::rsp_type   rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   logic                flag_mem [wpcm_pkg::MAX_WINDOW];
   logic                old_ff;
   wpcm_pkg::entry_type a_ff;
   logic                a_valid_ff, a_valid_in;

   logic [wpcm_pkg::PEAK_W-1:0]   peaks_ff, peaks_in;
   logic [wpcm_pkg::PEAK_W-1:0]   best_ff, best_in;
   logic [wpcm_pkg::OFFSET_W-1:0] best_pos_ff, best_pos_in;
   wpcm_pkg::rsp_type             out_ff, out_in;
   logic                          out_valid_ff, out_valid_in;

   logic                          b_go;
   logic                          advance;
   logic [wpcm_pkg::PEAK_W:0]     sum;
   logic [wpcm_pkg::PEAK_W-1:0]   cur;

   assign b_go      = a_valid_ff && !(a_ff.last && out_valid_ff && !rsp_pop);
   assign advance   = !a_valid_ff || b_go;
   assign head_pop  = advance && !head_empty;
   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (head_pop) begin
         if (head.wr_en) begin
            flag_mem[head.wr_addr] <= head.flag;
         end
         old_ff <= flag_mem[head.rd_addr];
         a_ff   <= head;
      end
   end

   always_comb begin
      sum = {1'b0, peaks_ff} + (wpcm_pkg::PEAK_W+1)'(a_ff.flag);
      if (a_ff.sub && (sum >= (wpcm_pkg::PEAK_W+1)'(old_ff))) begin
         sum = sum - (wpcm_pkg::PEAK_W+1)'(old_ff);
      end
      cur = sum[wpcm_pkg::PEAK_W-1:0];
   end

   always_comb begin
      a_valid_in   = advance ? !head_empty : a_valid_ff;
      peaks_in     = peaks_ff;
      best_in      = best_ff;
      best_pos_in  = best_pos_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (b_go) begin
         peaks_in = cur;
         if (a_ff.cand && (a_ff.first || (cur > best_ff))) begin
            best_in     = cur;
            best_pos_in = a_ff.start;
         end
         if (a_ff.last) begin
            out_valid_in = 1'b1;
            out_in.status = a_ff.status;
            if (a_ff.status == wpcm_pkg::STATUS_OK) begin
               out_in.best_peaks = best_in;
               out_in.best_start = wpcm_pkg::START_W'(best_pos_in) +
                                   wpcm_pkg::START_W'(1);
            end else begin
               out_in.best_peaks = '0;
               out_in.best_start = '0;
            end
            peaks_in    = '0;
            best_in     = '0;
            best_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         peaks_ff     <= '0;
         best_ff      <= '0;
         best_pos_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         peaks_ff     <= peaks_in;
         best_ff      <= best_in;
         best_pos_ff  <= best_pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
